>>> sv/two_level_feedback_queue_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Two-level feedback queue scheduler: assertion macros
// Shared concurrent assertion wrappers, clocked on clk, reset arst_n.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define TWO_LEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

// checked only outside reset
`define TLFQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TLFQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/tlfq_pkg.sv
// ----------------------------------------------------------------------------
// Two-level feedback queue scheduler package
// Sizes, item types, queue control types, pointer helper and work conversion helper.
// ----------------------------------------------------------------------------
package tlfq_pkg;

	localparam int JOB_SLOTS = 16;
	localparam int WORK_BITS = 16;
	localparam int ID_W      = 4;
	localparam int BURST_W   = 16;
	localparam int QUANT_W   = 8;
	localparam int TIME_W    = 32;
	localparam int PTR_W     = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam int CNT_W     = $clog2(JOB_SLOTS + 1);

	localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(2);

	typedef enum logic [1:0] {
		LVL_IDLE = 2'd0,
		LVL_TOP  = 2'd1,
		LVL_LOW  = 2'd2
	} level_t;

	typedef struct packed {
		logic               arrive_valid;
		logic [ID_W-1:0]    arrive_id;
		logic [BURST_W-1:0] arrive_burst;
	} arrive_t;

	typedef struct packed {
		level_t            run_level;
		logic [ID_W-1:0]   run_id;
		logic              done_valid;
		logic [ID_W-1:0]   done_id;
		logic [TIME_W-1:0] done_time;
		logic              overflow;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [WORK_BITS-1:0] work;
	} job_t;

	typedef struct packed {
		logic push0;
		logic push1;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic nonempty;
		logic drop0;
		logic drop1;
	} fifo_sts_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(JOB_SLOTS - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [WORK_BITS-1:0] to_work(input logic [BURST_W-1:0] burst);
		logic [63:0] w;
		w = 64'(burst);
		return w[WORK_BITS-1:0];
	endfunction

endpackage

>>> sv/tlfq_fifo.sv
// ----------------------------------------------------------------------------
// Job queue
// Register-file FIFO with two ordered push ports and one pop; full pushes
// are dropped and flagged. Pop of an empty queue takes the first push.
// ----------------------------------------------------------------------------
`include "two_level_feedback_queue_scheduler_defines.svh"

module tlfq_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  tlfq_pkg::fifo_ctl_t ctl,
	input  tlfq_pkg::job_t      push0_job,
	input  tlfq_pkg::job_t      push1_job,
	output tlfq_pkg::job_t      head_job,
	output tlfq_pkg::fifo_sts_t sts
);

	tlfq_pkg::job_t                  slots_q [tlfq_pkg::JOB_SLOTS];
	logic [tlfq_pkg::PTR_W-1:0]      head_q;
	logic [tlfq_pkg::PTR_W-1:0]      tail_q;
	logic [tlfq_pkg::CNT_W-1:0]      cnt_q;

	logic                            full0;
	logic                            ok0;
	logic                            ok1;
	logic [tlfq_pkg::CNT_W-1:0]      cnt_mid;
	logic [tlfq_pkg::PTR_W-1:0]      tail_mid;

	always_comb begin
		full0        = (cnt_q == tlfq_pkg::CNT_W'(tlfq_pkg::JOB_SLOTS));
		ok0          = ctl.push0 && !full0;
		cnt_mid      = cnt_q + tlfq_pkg::CNT_W'(ok0);
		ok1          = ctl.push1 && (cnt_mid != tlfq_pkg::CNT_W'(tlfq_pkg::JOB_SLOTS));
		tail_mid     = ok0 ? tlfq_pkg::next_ptr(tail_q) : tail_q;
		head_job     = (cnt_q == '0) ? push0_job : slots_q[head_q];
		sts.nonempty = (cnt_q != '0) || ok0;
		sts.drop0    = ctl.push0 && !ok0;
		sts.drop1    = ctl.push1 && !ok1;
	end

	always_ff @(posedge clk) begin
		if (ok0) begin
			slots_q[tail_q] <= push0_job;
		end
		if (ok1) begin
			slots_q[tail_mid] <= push1_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= ok1 ? tlfq_pkg::next_ptr(tail_mid) : tail_mid;
			if (ctl.pop) begin
				head_q <= tlfq_pkg::next_ptr(head_q);
			end
			cnt_q <= cnt_mid + tlfq_pkg::CNT_W'(ok1) - tlfq_pkg::CNT_W'(ctl.pop);
		end
	end

	`TLFQ_ASSERT_ALWAYS(a_cnt_range, cnt_q <= tlfq_pkg::CNT_W'(tlfq_pkg::JOB_SLOTS), "fifo count beyond depth")
	`TLFQ_ASSERT(a_pop_has_data, ctl.pop |-> (cnt_q != '0) || ok0, "pop of an empty fifo")
	`TLFQ_ASSERT(a_single_push, ok0 && !ok1 && !ctl.pop |=> cnt_q == $past(cnt_q) + tlfq_pkg::CNT_W'(1), "fifo count did not follow a push")

endmodule

>>> sv/two_level_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Two-level feedback queue scheduler
// Round-robin top level with quantum demotion into a first-come lower level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_item: one item per scheduler tick,
//   optionally carrying an arriving job. Output channel out_valid/out_stall/
//   out_item: exactly one result item per input item, in order.
//   cfg_we/cfg_wdata writes time_quantum; write it only while the block holds
//   no items. If the top level is not busy, the write also reloads the
//   remaining quantum.
//   An item accepted into the input register yields its result in the result
//   register once the output is free. Throughput: one item per cycle while the
//   output does not stall; the tick is one pass through the queue heads, three
//   decrements and compares between the input and result registers.
//   Reset: both queues empty, both levels idle, quantum 2, tick count zero.
//   Stall: the result register holds while out_stall is high; one more item
//   may wait in the input register, after which in_stall rises.
// ----------------------------------------------------------------------------
`include "two_level_feedback_queue_scheduler_defines.svh"

module two_level_feedback_queue_scheduler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tlfq_pkg::arrive_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tlfq_pkg::result_t               out_item,
	input  logic                            cfg_we,
	input  logic [tlfq_pkg::QUANT_W-1:0]    cfg_wdata
);

	logic                                 valid_s1;
	tlfq_pkg::arrive_t                    item_s1;
	logic                                 out_valid_q;
	tlfq_pkg::result_t                    out_item_q;

	logic [tlfq_pkg::QUANT_W-1:0]         quantum_q;
	logic [tlfq_pkg::QUANT_W-1:0]         quantum_left_q;
	logic [tlfq_pkg::TIME_W-1:0]          tick_q;
	logic                                 top_busy_q;
	tlfq_pkg::job_t                       top_job_q;
	logic                                 low_busy_q;
	tlfq_pkg::job_t                       low_job_q;

	logic                                 advance;
	logic                                 in_fire;

	tlfq_pkg::fifo_ctl_t                  top_ctl;
	tlfq_pkg::fifo_sts_t                  top_sts;
	tlfq_pkg::job_t                       top_head;
	tlfq_pkg::job_t                       arrive_job;
	tlfq_pkg::fifo_ctl_t                  low_ctl;
	tlfq_pkg::fifo_sts_t                  low_sts;
	tlfq_pkg::job_t                       low_head;
	tlfq_pkg::job_t                       demote_job;

	tlfq_pkg::job_t                       top_cur;
	logic [tlfq_pkg::WORK_BITS-1:0]       top_work_dec;
	logic [tlfq_pkg::QUANT_W-1:0]         qleft_dec;
	logic                                 top_ran;
	logic                                 top_done;
	logic                                 demote;
	tlfq_pkg::job_t                       low_cur;
	logic [tlfq_pkg::WORK_BITS-1:0]       low_work_dec;
	logic                                 low_ran;
	logic                                 low_done;
	logic [tlfq_pkg::TIME_W-1:0]          tick_inc;
	tlfq_pkg::result_t                    res;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		arrive_job.id   = item_s1.arrive_id;
		arrive_job.work = tlfq_pkg::to_work(item_s1.arrive_burst);
		top_ctl.push0   = advance && item_s1.arrive_valid;
		top_ctl.push1   = 1'b0;

		top_ran      = top_busy_q || top_sts.nonempty;
		top_ctl.pop  = advance && !top_busy_q && top_sts.nonempty;
		top_cur      = top_busy_q ? top_job_q : top_head;
		top_work_dec = top_cur.work - tlfq_pkg::WORK_BITS'(1);
		qleft_dec    = quantum_left_q - tlfq_pkg::QUANT_W'(1);
		top_done     = top_ran && (top_work_dec == '0);
		demote       = top_ran && !top_done && (qleft_dec == '0);

		demote_job.id   = top_cur.id;
		demote_job.work = top_work_dec;
		low_ctl.push0   = advance && demote;
		low_ctl.push1   = advance && top_ran && low_busy_q;

		low_ran      = !top_ran && (low_busy_q || low_sts.nonempty);
		low_ctl.pop  = advance && !top_ran && !low_busy_q && low_sts.nonempty;
		low_cur      = low_busy_q ? low_job_q : low_head;
		low_work_dec = low_cur.work - tlfq_pkg::WORK_BITS'(1);
		low_done     = low_ran && (low_work_dec == '0);

		tick_inc = tick_q + tlfq_pkg::TIME_W'(1);

		res.run_level  = tlfq_pkg::LVL_IDLE;
		res.run_id     = '0;
		res.done_valid = 1'b0;
		res.done_id    = '0;
		res.done_time  = '0;
		if (top_ran) begin
			res.run_level = tlfq_pkg::LVL_TOP;
			res.run_id    = top_cur.id;
		end else if (low_ran) begin
			res.run_level = tlfq_pkg::LVL_LOW;
			res.run_id    = low_cur.id;
		end
		if (top_done || low_done) begin
			res.done_valid = 1'b1;
			res.done_id    = res.run_id;
			res.done_time  = tick_inc;
		end
		res.overflow = top_sts.drop0 || low_sts.drop0 || low_sts.drop1;
	end

	tlfq_fifo u_top_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (top_ctl),
		.push0_job (arrive_job),
		.push1_job (arrive_job),
		.head_job  (top_head),
		.sts       (top_sts)
	);

	tlfq_fifo u_low_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (low_ctl),
		.push0_job (demote_job),
		.push1_job (low_job_q),
		.head_job  (low_head),
		.sts       (low_sts)
	);

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_item_q <= res;
			top_job_q.id   <= top_cur.id;
			top_job_q.work <= top_work_dec;
			low_job_q.id   <= low_cur.id;
			if (low_ran) begin
				low_job_q.work <= low_work_dec;
			end else begin
				low_job_q.work <= low_cur.work;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			quantum_q      <= tlfq_pkg::QUANT_RESET;
			quantum_left_q <= tlfq_pkg::QUANT_RESET;
			tick_q         <= '0;
			top_busy_q     <= 1'b0;
			low_busy_q     <= 1'b0;
		end else begin
			valid_s1    <= in_fire || (valid_s1 && !advance);
			out_valid_q <= advance || (out_valid_q && out_stall);
			if (advance) begin
				tick_q     <= tick_inc;
				top_busy_q <= top_ran && !top_done && !demote;
				if (top_ran) begin
					quantum_left_q <= (top_done || demote) ? quantum_q : qleft_dec;
				end
				if (top_ran) begin
					low_busy_q <= 1'b0;
				end else if (low_ran) begin
					low_busy_q <= !low_done;
				end
			end
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
				if (!top_busy_q) begin
					quantum_left_q <= cfg_wdata;
				end
			end
		end
	end

	`TLFQ_ASSERT(a_done_has_level, out_valid && out_item.done_valid |-> out_item.run_level != tlfq_pkg::LVL_IDLE, "completion reported on an idle tick")
	`TLFQ_ASSERT(a_idle_clean, out_valid && out_item.run_level == tlfq_pkg::LVL_IDLE |-> out_item.run_id == '0 && !out_item.done_valid, "idle tick carries job data")
	`TLFQ_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> valid_s1, "input stalled with an empty input stage")
	`TLFQ_ASSERT(a_single_level_busy, advance && top_ran |=> !low_busy_q, "lower level still busy after the top level ran")

endmodule
